@@ sv/bmorph_pkg.sv @@
// ----------------------------------------------------------------------------
// bmorph_pkg
// Shared sizes, register codes and stage descriptor of the 3x3 binary
// morphology block.
// ----------------------------------------------------------------------------
package bmorph_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // column index into the line store, row counter runs to height + 1
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    // register field widths
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int YX_W       = FH_W + 1;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(1024);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(1024);
    localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FH_MAX   = FH_W'(MAX_HEIGHT);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_MORPH_MODE   = 2'd2
    } cfg_idx_t;

    // one pixel slot on its way from the input register to the window
    typedef struct packed {
        logic             pix;
        logic [COL_W-1:0] col;
        logic             wrap;
        logic             emit;
        logic             top_ok;
        logic             bot_ok;
        logic             left_ok;
        logic             last;
    } stage_t;

endpackage

@@ sv/bmorph_if.sv @@
// ----------------------------------------------------------------------------
// bmorph_in_if / bmorph_out_if
// Valid/ready stream channels for pixel items and result items.
// ----------------------------------------------------------------------------
interface bmorph_in_if;
    logic valid;
    logic ready;
    logic op;
    logic pixel_in;

    modport source (output valid, output op, output pixel_in, input ready);
    modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface bmorph_out_if;
    logic valid;
    logic ready;
    logic pixel_out;
    logic last_of_frame;

    modport source (output valid, output pixel_out, output last_of_frame, input ready);
    modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

@@ sv/bmorph_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmorph_ctrl
// Configuration registers, raster position counters and the input stage
// register that feeds the window.
// ----------------------------------------------------------------------------
module bmorph_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bmorph_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [bmorph_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    input  logic                             in_op,
    input  logic                             in_pix,
    output logic                             in_ready,
    input  logic                             s1_adv,
    output logic                             enter,
    output logic [bmorph_pkg::COL_W-1:0]      rd_addr,
    output logic                             s1_valid,
    output bmorph_pkg::stage_t               s1_desc,
    output logic                             mode
);
    import bmorph_pkg::*;

    logic [FW_W-1:0]  fw_reg, fw_next;
    logic [FH_W-1:0]  fh_reg, fh_next;
    logic             mode_reg, mode_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             s1_valid_reg, s1_valid_next;
    stage_t           s1_desc_reg, s1_desc_next;

    logic [FW_W-1:0]  eff_w;
    logic [FH_W-1:0]  eff_h;
    logic [YX_W-1:0]  eh;
    logic [YX_W-1:0]  h_p1;
    logic [YX_W-1:0]  y_x;
    logic [FW_W-1:0]  x_p1;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic             accept;
    logic             flush;
    logic             drop;

    // sizes out of range saturate
    always_comb
    begin
        if (fw_reg == '0)
            eff_w = FW_W'(1);
        else if (fw_reg > FW_MAX)
            eff_w = FW_MAX;
        else
            eff_w = fw_reg;
        if (fh_reg == '0)
            eff_h = FH_W'(1);
        else if (fh_reg > FH_MAX)
            eff_h = FH_MAX;
        else
            eff_h = fh_reg;
    end

    assign eh   = {1'b0, eff_h};
    assign h_p1 = eh + YX_W'(1);

    always_comb
    begin
        if ((FW_W'(col_reg) >= eff_w) || (YX_W'(row_reg) > h_p1))
        begin
            col_cur = '0;
            row_cur = '0;
        end
        else
        begin
            col_cur = col_reg;
            row_cur = row_reg;
        end
    end

    assign y_x      = YX_W'(row_cur);
    assign x_p1     = FW_W'(col_cur) + FW_W'(1);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;
    assign flush    = (y_x >= eh);
    // a flush word inside the frame is swallowed without effect
    assign drop     = in_op && !flush;
    assign enter    = accept && !drop;
    assign rd_addr  = col_cur;

    always_comb
    begin
        s1_desc_next.pix  = flush ? 1'b0 : in_pix;
        s1_desc_next.col  = col_cur;
        s1_desc_next.wrap = (col_cur == '0);
        if (col_cur == '0)
        begin
            // center is the last column of the row two back
            s1_desc_next.emit    = (y_x >= YX_W'(2)) && (y_x <= h_p1);
            s1_desc_next.top_ok  = (y_x >= YX_W'(3));
            s1_desc_next.bot_ok  = (y_x <= eh);
            s1_desc_next.left_ok = (eff_w >= FW_W'(2));
            s1_desc_next.last    = (y_x == h_p1);
        end
        else
        begin
            s1_desc_next.emit    = (y_x >= YX_W'(1)) && (y_x <= eh);
            s1_desc_next.top_ok  = (y_x >= YX_W'(2));
            s1_desc_next.bot_ok  = (y_x < eh);
            s1_desc_next.left_ok = (col_cur >= COL_W'(2));
            s1_desc_next.last    = 1'b0;
        end
    end

    always_comb
    begin
        fw_next   = fw_reg;
        fh_next   = fh_reg;
        mode_next = mode_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_FRAME_WIDTH:
                begin
                    fw_next  = cfg_data[FW_W-1:0];
                    col_next = '0;
                    row_next = '0;
                end
                CFG_FRAME_HEIGHT:
                begin
                    fh_next  = cfg_data[FH_W-1:0];
                    col_next = '0;
                    row_next = '0;
                end
                CFG_MORPH_MODE:
                begin
                    mode_next = cfg_data[0];
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
        else if (accept)
        begin
            col_next = col_cur;
            row_next = row_cur;
            if (!drop)
            begin
                if (y_x == h_p1)
                begin
                    col_next = '0;
                    row_next = '0;
                end
                else if (x_p1 >= eff_w)
                begin
                    col_next = '0;
                    row_next = row_cur + ROW_W'(1);
                end
                else
                begin
                    col_next = x_p1[COL_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        if (enter)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg       <= FW_RESET;
            fh_reg       <= FH_RESET;
            mode_reg     <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            fw_reg       <= fw_next;
            fh_reg       <= fh_next;
            mode_reg     <= mode_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enter)
            s1_desc_reg <= s1_desc_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_desc  = s1_desc_reg;
    assign mode     = mode_reg;

endmodule

@@ sv/bmorph_line_store.sv @@
// ----------------------------------------------------------------------------
// bmorph_line_store
// Two line stores packed as one 2-bit wide memory, registered read with
// forwarding of a write to the same column in the same cycle.
// ----------------------------------------------------------------------------
module bmorph_line_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [bmorph_pkg::COL_W-1:0] rd_addr,
    input  logic                        wr_en,
    input  logic [bmorph_pkg::COL_W-1:0] wr_addr,
    input  logic                        wr_pix,
    output logic                        upper,
    output logic                        lower
);
    import bmorph_pkg::*;

    // bit 1 row two back, bit 0 row one back
    logic [1:0] mem [MAX_WIDTH];
    logic [1:0] rd_reg;
    logic [1:0] fwd_data_reg;
    logic       fwd_reg, fwd_next;
    logic [1:0] rd_eff;
    logic [1:0] wr_data;

    assign rd_eff  = fwd_reg ? fwd_data_reg : rd_reg;
    assign wr_data = {rd_eff[0], wr_pix};
    assign upper   = rd_eff[1];
    assign lower   = rd_eff[0];

    always_comb
    begin
        if (rd_en)
            fwd_next = wr_en && (wr_addr == rd_addr);
        else
            fwd_next = fwd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_reg       <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else
            fwd_reg <= fwd_next;
    end

endmodule

@@ sv/bmorph_window.sv @@
// ----------------------------------------------------------------------------
// bmorph_window
// 3x3 window shift register, erosion / dilation kernel and result register.
// ----------------------------------------------------------------------------
module bmorph_window (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s1_valid,
    input  bmorph_pkg::stage_t s1_desc,
    input  logic               upper,
    input  logic               lower,
    input  logic               mode,
    output logic               s1_adv,
    bmorph_out_if.source       res
);
    import bmorph_pkg::*;

    logic [8:0] window_reg, window_next;
    logic       out_valid_reg, out_valid_next;
    logic       pix_reg;
    logic       last_reg;

    logic [8:0] win;
    logic [2:0] col_l, col_c, col_r;
    logic [2:0] row_mask;
    logic       cval;
    logic       diff;
    logic       result;

    assign s1_adv      = s1_valid && (!out_valid_reg || res.ready);
    assign window_next = {s1_desc.pix, lower, upper, window_reg[8:3]};

    // at the start of a row the center sits in the window before the shift
    assign win   = s1_desc.wrap ? window_reg : window_next;
    assign col_l = s1_desc.wrap ? win[5:3] : win[2:0];
    assign col_c = s1_desc.wrap ? win[8:6] : win[5:3];
    assign col_r = win[8:6];

    assign row_mask = {s1_desc.bot_ok, 1'b1, s1_desc.top_ok};
    assign cval     = col_c[1];

    assign diff = (|((col_l ^ {3{cval}}) & row_mask & {3{s1_desc.left_ok}}))
                | (|((col_c ^ {3{cval}}) & row_mask))
                | (|((col_r ^ {3{cval}}) & row_mask & {3{!s1_desc.wrap}}));

    assign result = diff ? mode : cval;

    always_comb
    begin
        if (s1_adv)
            out_valid_next = s1_desc.emit;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                window_reg <= window_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            pix_reg  <= result;
            last_reg <= s1_desc.last;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.pixel_out     = pix_reg;
    assign res.last_of_frame = last_reg;

endmodule

@@ sv/binary_morphology_3x3.sv @@
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// 3x3 binary erosion / dilation over a raster pixel stream.
// ----------------------------------------------------------------------------
//  channel   dir   handshake     payload
//  pixels    in    valid/ready   op, pixel_in
//  results   out   valid/ready   pixel_out, last_of_frame
//  cfg       in    cfg_we        cfg_idx, cfg_data
//
//  one word per clock sustained while results are taken; a word passes the input
//  stage (line store read) and then the window stage before its result shows.
//  results lag their pixel by one row plus one pixel; width + 1 flush words
//  after the last pixel drain the frame tail.
//  reset clears counters, window and valids; line store contents are not
//  cleared, stale entries only ever land on masked neighbours.
//  a stalled result holds the window stage, which then holds pixels.ready low.
// ----------------------------------------------------------------------------
module binary_morphology_3x3 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bmorph_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [bmorph_pkg::CFG_DATA_W-1:0] cfg_data,
    bmorph_in_if.sink                        pixels,
    bmorph_out_if.source                     results
);
    import bmorph_pkg::*;

    logic             s1_adv;
    logic             enter;
    logic [COL_W-1:0] rd_addr;
    logic             s1_valid;
    stage_t           s1_desc;
    logic             mode;
    logic             upper;
    logic             lower;

    bmorph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_valid (pixels.valid),
        .in_op    (pixels.op),
        .in_pix   (pixels.pixel_in),
        .in_ready (pixels.ready),
        .s1_adv   (s1_adv),
        .enter    (enter),
        .rd_addr  (rd_addr),
        .s1_valid (s1_valid),
        .s1_desc  (s1_desc),
        .mode     (mode)
    );

    bmorph_line_store u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (enter),
        .rd_addr (rd_addr),
        .wr_en   (s1_adv),
        .wr_addr (s1_desc.col),
        .wr_pix  (s1_desc.pix),
        .upper   (upper),
        .lower   (lower)
    );

    bmorph_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_desc  (s1_desc),
        .upper    (upper),
        .lower    (lower),
        .mode     (mode),
        .s1_adv   (s1_adv),
        .res      (results)
    );

    // a stalled result must freeze the window stage
    a_stall_holds_window: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.ready |-> !s1_adv)
        else $error("window stage advanced under a stalled result");

    // an occupied, stuck window stage takes no new word
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && !s1_adv |-> !enter)
        else $error("input stage overwritten while occupied");

    // each advance yields a result exactly when the slot was marked to emit
    a_emit_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> results.valid == $past(s1_desc.emit))
        else $error("result valid does not match emitted slot");

endmodule
